// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ogm_pkg.sv
`timescale 1ns / 1ps
package ogm_pkg;

   localparam logic [2:0] MODE_SET   = 3'd0;
   localparam logic [2:0] MODE_RECT  = 3'd1;
   localparam logic [2:0] MODE_QUERY = 3'd2;
   localparam logic [2:0] MODE_NEIGH = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // neighbour steps in the order +x, -x, +y, -y
   localparam logic [1:0] NB_DX [4] = '{2'b01, 2'b11, 2'b00, 2'b00};
   localparam logic [1:0] NB_DY [4] = '{2'b00, 2'b00, 2'b01, 2'b11};

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_BOUNDS,
      ST_NB_START,
      ST_ADDR,
      ST_WRITE,
      ST_READ,
      ST_CHECK,
      ST_EMIT,
      ST_WIPE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_PORT,
      CUR_RECT,
      CUR_NEXT_X,
      CUR_NEXT_ROW,
      CUR_NB
   } cur_sel_type;

   typedef enum logic [1:0] {
      OUT_PLAIN,
      OUT_WALK,
      OUT_NB
   } out_kind_type;

   typedef struct packed {
      logic         load_req;
      cur_sel_type  cur_sel;
      logic         nb_clr;
      logic         nb_adv;
      logic         calc_row;
      logic         mem_write;
      logic         mem_read;
      logic         mask_capture;
      logic         clr_start;
      logic         clr_step;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       x_end;
      logic       y_end;
      logic       scan_done;
      logic       nb_final;
      logic       emit_last;
      logic       out_free;
   } sts_type;

endpackage

// File: rtl/core/ogm_dp.sv
`timescale 1ns / 1ps
module ogm_dp
   import ogm_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [2:0]         req_mode,
   input  logic signed [15:0] req_cell_x,
   input  logic signed [15:0] req_cell_y,
   input  logic signed [15:0] req_corner_x,
   input  logic signed [15:0] req_corner_y,
   input  logic               req_set_value,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_walkable,
   output logic               rsp_nb_valid,
   output logic [5:0]         rsp_nb_x,
   output logic [5:0]         rsp_nb_y,
   output logic               rsp_last
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int W_RST = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
   localparam int H_RST = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

   logic [2:0]         mode_ff;
   logic signed [15:0] cx_ff, cy_ff, kx_ff, ky_ff;
   logic               val_ff;
   logic [WW-1:0]      eff_w_ff, eff_w_in;
   logic [HW-1:0]      eff_h_ff, eff_h_in;
   logic signed [16:0] cur_x_ff, cur_x_in;
   logic signed [16:0] cur_y_ff, cur_y_in;
   logic [XW-1:0]      x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0]      y1_ff, y1_in, y0_in;
   logic [AW-1:0]      row_ff, row_in;
   logic [AW-1:0]      scan_ff, scan_in;
   logic [1:0]         nb_idx_ff, nb_idx_in;
   logic [3:0]         mask_ff, mask_rest;
   logic               rd_ff, ingrid_ff;
   logic               rsp_valid_ff;
   logic               walk_ff, nbv_ff, last_ff;
   logic [5:0]         nbx_ff, nby_ff;

   logic [YW+WW-1:0]   prod;
   logic [AW-1:0]      addr, waddr;
   logic               in_grid, mem_we, wbit, scan_done;
   logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
   logic [1:0]         sel, dx, dy, ex, ey;
   logic               map_mem [CELLS];

   function automatic logic [15:0] clamp_dim(input logic signed [15:0] v,
                                             input logic [15:0] lim);
      logic [15:0] r;
      if (v[15]) begin
         r = '0;
      end else if ($unsigned(v) > lim) begin
         r = lim;
      end else begin
         r = $unsigned(v);
      end
      return r;
   endfunction

   // geometry registers
   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_write && csr_index == CSR_WIDTH) begin
         if (csr_wdata == 7'd0) begin
            eff_w_in = WW'(1);
         end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
            eff_w_in = WW'(MAX_WIDTH);
         end else begin
            eff_w_in = WW'(csr_wdata);
         end
      end
      if (csr_write && csr_index == CSR_HEIGHT) begin
         if (csr_wdata == 7'd0) begin
            eff_h_in = HW'(1);
         end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
            eff_h_in = HW'(MAX_HEIGHT);
         end else begin
            eff_h_in = HW'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= WW'(W_RST);
         eff_h_ff <= HW'(H_RST);
      end else begin
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         cx_ff   <= req_cell_x;
         cy_ff   <= req_cell_y;
         kx_ff   <= req_corner_x;
         ky_ff   <= req_corner_y;
         val_ff  <= req_set_value;
      end
   end

   // rectangle bounds, ordered and clamped
   always_comb begin
      lo_x  = (cx_ff < kx_ff) ? cx_ff : kx_ff;
      hi_x  = (cx_ff < kx_ff) ? kx_ff : cx_ff;
      lo_y  = (cy_ff < ky_ff) ? cy_ff : ky_ff;
      hi_y  = (cy_ff < ky_ff) ? ky_ff : cy_ff;
      x0_in = XW'(clamp_dim(lo_x, 16'(eff_w_ff) - 16'd1));
      x1_in = XW'(clamp_dim(hi_x, 16'(eff_w_ff) - 16'd1));
      y0_in = YW'(clamp_dim(lo_y, 16'(eff_h_ff) - 16'd1));
      y1_in = YW'(clamp_dim(hi_y, 16'(eff_h_ff) - 16'd1));
   end

   always_ff @(posedge clock) begin
      if (cmd.cur_sel == CUR_RECT) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
      end
   end

   // neighbour index
   always_comb begin
      nb_idx_in = nb_idx_ff;
      if (cmd.nb_clr) begin
         nb_idx_in = 2'd0;
      end else if (cmd.nb_adv) begin
         nb_idx_in = nb_idx_ff + 2'd1;
      end
      dx = NB_DX[nb_idx_in];
      dy = NB_DY[nb_idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_idx_ff <= 2'd0;
      end else begin
         nb_idx_ff <= nb_idx_in;
      end
   end

   // cursor
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      unique case (cmd.cur_sel)
         CUR_HOLD: begin
         end
         CUR_PORT: begin
            cur_x_in = {req_cell_x[15], req_cell_x};
            cur_y_in = {req_cell_y[15], req_cell_y};
         end
         CUR_RECT: begin
            cur_x_in = 17'(x0_in);
            cur_y_in = 17'(y0_in);
         end
         CUR_NEXT_X: begin
            cur_x_in = cur_x_ff + 17'sd1;
         end
         CUR_NEXT_ROW: begin
            cur_x_in = 17'(x0_ff);
            cur_y_in = cur_y_ff + 17'sd1;
         end
         CUR_NB: begin
            cur_x_in = {cx_ff[15], cx_ff} + {{15{dx[1]}}, dx};
            cur_y_in = {cy_ff[15], cy_ff} + {{15{dy[1]}}, dy};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
   end

   // address generation
   assign in_grid = !cur_x_ff[16] && (cur_x_ff[15:0] < 16'(eff_w_ff))
                 && !cur_y_ff[16] && (cur_y_ff[15:0] < 16'(eff_h_ff));
   assign prod    = cur_y_ff[YW-1:0] * eff_w_ff;
   assign row_in  = AW'(prod);
   assign addr    = row_ff + AW'(cur_x_ff[XW-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.calc_row) begin
         row_ff <= row_in;
      end
   end

   // clear sweep pointer
   assign scan_done = (scan_ff == AW'(CELLS - 1));

   always_comb begin
      scan_in = scan_ff;
      if (cmd.clr_start) begin
         scan_in = '0;
      end else if (cmd.clr_step) begin
         scan_in = scan_done ? '0 : scan_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   // map memory
   assign mem_we = cmd.clr_step || (cmd.mem_write && in_grid);
   assign waddr  = cmd.clr_step ? scan_ff : addr;
   assign wbit   = cmd.clr_step ? 1'b0 : val_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[waddr] <= wbit;
      end
      if (cmd.mem_read) begin
         rd_ff     <= map_mem[addr];
         ingrid_ff <= in_grid;
      end
   end

   // free-neighbour mask
   always_comb begin
      priority if (mask_ff[0]) begin
         sel = 2'd0;
      end else if (mask_ff[1]) begin
         sel = 2'd1;
      end else if (mask_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
      mask_rest = mask_ff & (mask_ff - 4'd1);
      ex        = NB_DX[sel];
      ey        = NB_DY[sel];
   end

   always_ff @(posedge clock) begin
      if (cmd.mask_capture) begin
         mask_ff[nb_idx_ff] <= ingrid_ff & ~rd_ff;
      end else if (cmd.out_load && cmd.out_kind == OUT_NB) begin
         mask_ff <= mask_rest;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_kind)
            OUT_WALK: begin
               walk_ff <= ingrid_ff & ~rd_ff;
               nbv_ff  <= 1'b0;
               nbx_ff  <= 6'd0;
               nby_ff  <= 6'd0;
               last_ff <= 1'b1;
            end
            OUT_NB: begin
               walk_ff <= 1'b0;
               nbv_ff  <= |mask_ff;
               nbx_ff  <= (|mask_ff) ? cx_ff[5:0] + {{4{ex[1]}}, ex} : 6'd0;
               nby_ff  <= (|mask_ff) ? cy_ff[5:0] + {{4{ey[1]}}, ey} : 6'd0;
               last_ff <= (mask_rest == 4'd0);
            end
            default: begin
               walk_ff <= 1'b0;
               nbv_ff  <= 1'b0;
               nbx_ff  <= 6'd0;
               nby_ff  <= 6'd0;
               last_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_walkable = walk_ff;
   assign rsp_nb_valid = nbv_ff;
   assign rsp_nb_x     = nbx_ff;
   assign rsp_nb_y     = nby_ff;
   assign rsp_last     = last_ff;

   assign sts.mode      = mode_ff;
   assign sts.x_end     = (cur_x_ff[XW-1:0] == x1_ff);
   assign sts.y_end     = (cur_y_ff[YW-1:0] == y1_ff);
   assign sts.scan_done = scan_done;
   assign sts.nb_final  = (nb_idx_ff == 2'd3);
   assign sts.emit_last = (mask_rest == 4'd0);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

endmodule

// File: rtl/core/ogm_ctrl.sv
`timescale 1ns / 1ps
module ogm_ctrl
   import ogm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_mode,
   output logic       req_stall,
   input  logic       csr_write,
   input  sts_type    sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = csr_write;
            if (!csr_write && req_valid) begin
               cmd.load_req = 1'b1;
               cmd.cur_sel  = CUR_PORT;
               unique case (req_mode)
                  MODE_SET, MODE_QUERY: begin
                     state_in = ST_ADDR;
                  end
                  MODE_RECT: begin
                     state_in = ST_BOUNDS;
                  end
                  MODE_NEIGH: begin
                     cmd.nb_clr = 1'b1;
                     state_in   = ST_NB_START;
                  end
                  MODE_CLEAR: begin
                     cmd.clr_start = 1'b1;
                     state_in      = ST_WIPE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_BOUNDS: begin
            cmd.cur_sel = CUR_RECT;
            state_in    = ST_ADDR;
         end
         ST_NB_START: begin
            cmd.cur_sel = CUR_NB;
            state_in    = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.calc_row = 1'b1;
            if (sts.mode == MODE_SET || sts.mode == MODE_RECT) begin
               state_in = ST_WRITE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            if (sts.mode == MODE_RECT && !(sts.x_end && sts.y_end)) begin
               if (sts.x_end) begin
                  cmd.cur_sel = CUR_NEXT_ROW;
                  state_in    = ST_ADDR;
               end else begin
                  cmd.cur_sel = CUR_NEXT_X;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.mode == MODE_QUERY) begin
               if (sts.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = OUT_WALK;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.mask_capture = 1'b1;
               if (sts.nb_final) begin
                  state_in = ST_EMIT;
               end else begin
                  cmd.nb_adv  = 1'b1;
                  cmd.cur_sel = CUR_NB;
                  state_in    = ST_ADDR;
               end
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_NB;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WIPE: begin
            cmd.clr_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_PLAIN;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      // a size write restarts the clear sweep
      if (csr_write) begin
         cmd.clr_start = 1'b1;
         state_in      = ST_INIT;
      end
   end

endmodule

// File: rtl/core/occupancy_grid_map_top.sv
// Set cell writes one cell; query reads one cell; neighbours reads the four cells around it.
// Rectangle writes its cells row by row; clear all sweeps all MAX_WIDTH*MAX_HEIGHT cells.
// One item at a time; the next item is taken as the result of the last one appears.
// A finished result waits in the output register while the next item runs.
// Reset and every csr write sweep the map to zero, all MAX_WIDTH*MAX_HEIGHT cells,
// with req_stall high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module occupancy_grid_map_top
   import ogm_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [15:0] req_cell_x,
   input  logic signed [15:0] req_cell_y,
   input  logic signed [15:0] req_corner_x,
   input  logic signed [15:0] req_corner_y,
   input  logic               req_set_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_walkable,
   output logic               rsp_nb_valid,
   output logic [5:0]         rsp_nb_x,
   output logic [5:0]         rsp_nb_y,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata
);

   cmd_type ctrl_cmd;
   sts_type dp_sts;

   ogm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .csr_write (csr_write),
      .sts       (dp_sts),
      .cmd       (ctrl_cmd)
   );

   ogm_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (ctrl_cmd),
      .sts           (dp_sts),
      .req_mode      (req_mode),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_corner_x  (req_corner_x),
      .req_corner_y  (req_corner_y),
      .req_set_value (req_set_value),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_walkable  (rsp_walkable),
      .rsp_nb_valid  (rsp_nb_valid),
      .rsp_nb_x      (rsp_nb_x),
      .rsp_nb_y      (rsp_nb_y),
      .rsp_last      (rsp_last)
   );

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "item accepted while busy")
   `ASSERT_NEXT(a_sweep_after_csr, clock, reset, csr_write, req_stall, "csr write did not start clear")
   `ASSERT_IMPLIES(a_out_no_overwrite, clock, reset, ctrl_cmd.out_load, !rsp_valid || !rsp_stall, "result overwritten")
   `ASSERT_IMPLIES(a_more_only_nb, clock, reset, rsp_valid && !rsp_last, rsp_nb_valid && !rsp_walkable, "bad non-final result")

endmodule
